// ----- hdl/deq_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// deq_pkg - shared types for the double-ended queue
// Operation, status and controller state codes, and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package deq_pkg;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;

    // request kind as it arrives on the input channel
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK_FRONT = 3'd4,
        KIND_PEEK_BACK  = 3'd5
    } kind_t;

    // result status code
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_NULL  = 2'd3
    } status_t;

    // datapath operation issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_PEEK_FRONT,
        OP_PEEK_BACK
    } op_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_READ,
        FSM_RESP
    } fsm_state_t;

    // controller to datapath
    typedef struct packed {
        op_t     op;       // pointer, count and store update, read issue
        logic    capture;  // load the result registers
        logic    use_rd;   // result word comes from the store read
        status_t code;     // status to report
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic q_empty;
        logic q_full;
        logic word_null;
    } dp_status_t;

endpackage

// ----- hdl/deq_in_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// deq_in_if - request channel
// Valid/ready channel carrying one queue operation per beat.
// ============================================================================
interface deq_in_if;

    logic                           valid;
    logic                           ready;
    logic [deq_pkg::KIND_W-1:0]     kind;
    logic [deq_pkg::VALUE_W-1:0]    value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

// ----- hdl/deq_out_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// deq_out_if - response channel
// Valid/ready channel carrying one operation result per beat.
// ============================================================================
interface deq_out_if #(
    parameter int unsigned COUNT_W = 5
);

    logic                           valid;
    logic                           ready;
    logic [deq_pkg::VALUE_W-1:0]    value_out;
    logic [deq_pkg::STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]             count;
    logic                           is_empty;

    modport source (output valid, output value_out, output status, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input value_out, input status, input count,
                    input is_empty, output ready);

endinterface

// ----- hdl/deq_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// deq_ctrl - queue controller
// Decodes each request against the queue state and sequences the datapath.
// ============================================================================
module deq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [deq_pkg::KIND_W-1:0]  kind,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  deq_pkg::dp_status_t         dp_stat,
    output deq_pkg::cmd_t               cmd
);

    deq_pkg::fsm_state_t state_reg;
    deq_pkg::fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.op      = deq_pkg::OP_NONE;
        cmd.capture = 1'b0;
        cmd.use_rd  = 1'b0;
        cmd.code    = deq_pkg::STAT_OK;

        case (state_reg)
            deq_pkg::FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = deq_pkg::FSM_RESP;
                    case (deq_pkg::kind_t'(kind))
                        deq_pkg::KIND_PUSH_BACK,
                        deq_pkg::KIND_PUSH_FRONT:
                        begin
                            // null check takes priority over full
                            if (dp_stat.word_null)
                            begin
                                cmd.code = deq_pkg::STAT_NULL;
                            end
                            else if (dp_stat.q_full)
                            begin
                                cmd.code = deq_pkg::STAT_FULL;
                            end
                            else if (deq_pkg::kind_t'(kind) == deq_pkg::KIND_PUSH_BACK)
                            begin
                                cmd.op = deq_pkg::OP_PUSH_BACK;
                            end
                            else
                            begin
                                cmd.op = deq_pkg::OP_PUSH_FRONT;
                            end
                        end
                        deq_pkg::KIND_POP_FRONT,
                        deq_pkg::KIND_POP_BACK,
                        deq_pkg::KIND_PEEK_FRONT,
                        deq_pkg::KIND_PEEK_BACK:
                        begin
                            if (dp_stat.q_empty)
                            begin
                                cmd.code = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // result waits for the registered store read
                                cmd.capture = 1'b0;
                                state_next  = deq_pkg::FSM_READ;
                                case (deq_pkg::kind_t'(kind))
                                    deq_pkg::KIND_POP_FRONT:  cmd.op = deq_pkg::OP_POP_FRONT;
                                    deq_pkg::KIND_POP_BACK:   cmd.op = deq_pkg::OP_POP_BACK;
                                    deq_pkg::KIND_PEEK_FRONT: cmd.op = deq_pkg::OP_PEEK_FRONT;
                                    default:                  cmd.op = deq_pkg::OP_PEEK_BACK;
                                endcase
                            end
                        end
                        default:
                        begin
                            // unused kinds report the current count only
                        end
                    endcase
                end
            end
            deq_pkg::FSM_READ:
            begin
                cmd.capture = 1'b1;
                cmd.use_rd  = 1'b1;
                state_next  = deq_pkg::FSM_RESP;
            end
            deq_pkg::FSM_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = deq_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::FSM_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/deq_dp.sv -----
`timescale 1ns / 1ps
// ============================================================================
// deq_dp - queue datapath
// Ring buffer store, front/back indices, entry count and result registers.
// ============================================================================
module deq_dp #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned COUNT_W    = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [deq_pkg::VALUE_W-1:0]     value,
    input  deq_pkg::cmd_t                   cmd,
    output deq_pkg::dp_status_t             dp_stat,
    output logic [deq_pkg::VALUE_W-1:0]     value_out,
    output logic [deq_pkg::STATUS_W-1:0]    status,
    output logic [COUNT_W-1:0]              count,
    output logic                            is_empty
);

    localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned WORD_W = (DATA_WIDTH < deq_pkg::VALUE_W) ? DATA_WIDTH
                                                                     : deq_pkg::VALUE_W;

    logic [WORD_W-1:0]              mem [DEPTH];
    logic [WORD_W-1:0]              rd_data_reg;

    logic [IDX_W-1:0]               front_reg;
    logic [IDX_W-1:0]               front_next;
    logic [IDX_W-1:0]               back_reg;
    logic [IDX_W-1:0]               back_next;
    logic [COUNT_W-1:0]             count_reg;
    logic [COUNT_W-1:0]             count_next;

    logic [IDX_W-1:0]               front_up;
    logic [IDX_W-1:0]               front_down;
    logic [IDX_W-1:0]               back_up;
    logic [IDX_W-1:0]               back_down;
    logic [IDX_W-1:0]               rd_addr;
    logic [IDX_W-1:0]               wr_addr;
    logic                           wr_en;
    logic [WORD_W-1:0]              word;

    logic [deq_pkg::VALUE_W-1:0]    value_out_reg;
    logic [deq_pkg::STATUS_W-1:0]   status_reg;
    logic [COUNT_W-1:0]             res_count_reg;
    logic                           is_empty_reg;

    assign word = value[WORD_W-1:0];

    // ring wrap, depth need not be a power of two
    assign front_up   = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_down = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign back_up    = (back_reg == IDX_W'(DEPTH - 1)) ? '0 : back_reg + 1'b1;
    assign back_down  = (back_reg == '0) ? IDX_W'(DEPTH - 1) : back_reg - 1'b1;

    assign dp_stat.q_empty   = (count_reg == '0);
    assign dp_stat.q_full    = (count_reg == COUNT_W'(DEPTH));
    assign dp_stat.word_null = (word == '0);

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        rd_addr    = front_reg;
        wr_addr    = back_reg;
        wr_en      = 1'b0;
        case (cmd.op)
            deq_pkg::OP_PUSH_BACK:
            begin
                wr_en      = 1'b1;
                wr_addr    = back_reg;
                back_next  = back_up;
                count_next = count_reg + 1'b1;
            end
            deq_pkg::OP_PUSH_FRONT:
            begin
                wr_en      = 1'b1;
                wr_addr    = front_down;
                front_next = front_down;
                count_next = count_reg + 1'b1;
            end
            deq_pkg::OP_POP_FRONT:
            begin
                rd_addr    = front_reg;
                front_next = front_up;
                count_next = count_reg - 1'b1;
            end
            deq_pkg::OP_POP_BACK:
            begin
                rd_addr    = back_down;
                back_next  = back_down;
                count_next = count_reg - 1'b1;
            end
            deq_pkg::OP_PEEK_FRONT:
            begin
                rd_addr = front_reg;
            end
            deq_pkg::OP_PEEK_BACK:
            begin
                rd_addr = back_down;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= word;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_out_reg <= cmd.use_rd ? deq_pkg::VALUE_W'(rd_data_reg) : '0;
            status_reg    <= cmd.code;
            res_count_reg <= count_next;
            is_empty_reg  <= (count_next == '0);
        end
    end

    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign count     = res_count_reg;
    assign is_empty  = is_empty_reg;

endmodule

// ----- hdl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// response: a push, an unused kind or an empty pop/peek offers its response in the cycle
//   after the request beat; a pop or peek on a non-empty queue first passes the registered
//   read of the entry store (FSM_READ) and then loads the result registers
// flow: a new request is taken only once the previous response beat has gone
// reset: rst_n clears indices, count and controller state at once; the store keeps
//   no reset and holds nothing valid until written
// ============================================================================
// double_ended_queue - bounded deque of data words
// Ring buffer deque with push/pop/peek at either end, controller plus datapath.
// ============================================================================
module double_ended_queue #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    deq_in_if.sink      req,
    deq_out_if.source   rsp
);

    // count must hold DEPTH itself
    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

    deq_pkg::cmd_t       cmd;      // controller command to datapath
    deq_pkg::dp_status_t dp_stat;  // queue condition back to controller

    // controller: decodes request kind against empty/full/null, owns both
    // handshakes, one request in flight at a time
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .kind      (req.kind),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .dp_stat   (dp_stat),
        .cmd       (cmd)
    );

    // datapath: ring buffer store, indices, count and response registers;
    // response payload is held in registers for the whole response beat
    deq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .COUNT_W    (COUNT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (req.value),
        .cmd       (cmd),
        .dp_stat   (dp_stat),
        .value_out (rsp.value_out),
        .status    (rsp.status),
        .count     (rsp.count),
        .is_empty  (rsp.is_empty)
    );

endmodule

// ----- hdl/deq_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// deq_checker - port level checks for the deque
// Watches the request and response channels of the top level.
// ============================================================================
module deq_checker #(
    parameter int unsigned DEPTH   = 16,
    parameter int unsigned COUNT_W = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_ready,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  logic [deq_pkg::VALUE_W-1:0]     value_out,
    input  logic [deq_pkg::STATUS_W-1:0]    status,
    input  logic [COUNT_W-1:0]              count,
    input  logic                            is_empty
);

    // count never exceeds the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (count <= COUNT_W'(DEPTH)))
        else $error("deq: count above depth");

    // empty flag agrees with the count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (count == '0)))
        else $error("deq: empty flag disagrees with count");

    // a response with a non-ok status returns no word
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != deq_pkg::STAT_OK) |-> (value_out == '0))
        else $error("deq: word returned with non-ok status");

    // no new request while a response is outstanding
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("deq: request taken with response pending");

    // stalled response stays valid and holds its word and count
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(value_out) && $stable(count)))
        else $error("deq: stalled response changed");

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH   (DEPTH),
    .COUNT_W ($clog2(DEPTH + 1))
) u_deq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .value_out (rsp.value_out),
    .status    (rsp.status),
    .count     (rsp.count),
    .is_empty  (rsp.is_empty)
);
